@@ hw/rtl/lcdt_pkg.sv @@
package lcdt_pkg;

    localparam int KEY_BITS    = 48;
    localparam int COUNT_BITS  = 32;
    localparam int CFG_BITS    = 7;
    localparam int ENTRIES_DEF = 64;

    localparam logic [CFG_BITS-1:0] CACHE_SIZE_RESET = CFG_BITS'(64);

    // Request codes
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [KEY_BITS-1:0] page_key;
        logic                is_write;
    } req_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] call_count;
        logic [COUNT_BITS-1:0] hit_count;
        logic [COUNT_BITS-1:0] read_hit_count;
        logic [COUNT_BITS-1:0] write_hit_count;
        logic [COUNT_BITS-1:0] dirty_evict_count;
    } counts_t;

    typedef struct packed {
        logic                  hit;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
        logic                  evicted_dirty;
        logic [COUNT_BITS-1:0] call_count;
        logic [COUNT_BITS-1:0] hit_count;
        logic [COUNT_BITS-1:0] read_hit_count;
        logic [COUNT_BITS-1:0] write_hit_count;
        logic [COUNT_BITS-1:0] dirty_evict_count;
    } rsp_t;

    // Update strobe and outcome of one item, from the sequencer to the counters
    typedef struct packed {
        logic fire;
        logic access;
        logic clear;
        logic hit;
        logic wr;
        logic dirty_evict;
    } stats_upd_t;

endpackage

@@ hw/rtl/lcdt_cell.sv @@
module lcdt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [lcdt_pkg::KEY_BITS-1:0] in_key,
    input  logic                          in_dirty,
    input  logic [lcdt_pkg::KEY_BITS-1:0] cmp_key,
    output logic [lcdt_pkg::KEY_BITS-1:0] key,
    output logic                          valid,
    output logic                          dirty,
    output logic                          match
);

    logic [lcdt_pkg::KEY_BITS-1:0] key_reg;
    logic                          valid_reg;
    logic                          dirty_reg;
    logic                          match_reg;
    logic                          match_next;

    assign match_next = valid_reg && (key_reg == cmp_key);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= in_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            // anything shifted in or inserted is a live entry
            if (load)
            begin
                valid_reg <= 1'b1;
                dirty_reg <= in_dirty;
            end
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign dirty = dirty_reg;
    assign match = match_reg;

endmodule

@@ hw/rtl/lcdt_stats.sv @@
module lcdt_stats (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcdt_pkg::stats_upd_t   upd,
    output lcdt_pkg::counts_t      cnt_next
);

    lcdt_pkg::counts_t cnt_reg;

    function automatic logic [lcdt_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [lcdt_pkg::COUNT_BITS-1:0] v,
        input logic                            en
    );
        logic [lcdt_pkg::COUNT_BITS-1:0] r;
        r = v;
        if (en && (v != {lcdt_pkg::COUNT_BITS{1'b1}}))
        begin
            r = v + lcdt_pkg::COUNT_BITS'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        cnt_next = cnt_reg;
        if (upd.clear)
        begin
            cnt_next.call_count = '0;
            cnt_next.hit_count  = '0;
        end
        else if (upd.access)
        begin
            cnt_next.call_count        = sat_inc(cnt_reg.call_count, 1'b1);
            cnt_next.hit_count         = sat_inc(cnt_reg.hit_count, upd.hit);
            cnt_next.read_hit_count    = sat_inc(cnt_reg.read_hit_count,
                                                 upd.hit && !upd.wr);
            cnt_next.write_hit_count   = sat_inc(cnt_reg.write_hit_count,
                                                 upd.hit && upd.wr);
            cnt_next.dirty_evict_count = sat_inc(cnt_reg.dirty_evict_count,
                                                 upd.dirty_evict);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (upd.fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/lru_cache_dirty_tracker.sv @@
// Fully associative LRU cache directory with write-back dirty marks. Entries
// live in a row of cells kept in recency order: cell 0 holds the most recent
// entry and the live entries fill cells 0..occupancy-1. Each item passes
// three steps: accept; match, in which every cell compares its key against
// the item in parallel and registers the match; update, in which the hit or
// stop position is encoded and cells 0..stop load from their left neighbor
// while cell 0 takes the accessed key. The result sits in an output register,
// so the next item is accepted while a result still waits to be taken; the
// update step of that next item holds until the waiting result is taken. A
// clear item zeroes only the call and hit counters. cache_size may be written
// at any time the block is idle; 0 acts as 1 and values above ENTRIES act as
// ENTRIES. If the size is shrunk below the occupancy, each miss evicts one
// least recent entry and inserts, so occupancy holds.
module lru_cache_dirty_tracker #(
    parameter int ENTRIES = lcdt_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc_valid,
    output logic                          acc_ready,
    input  lcdt_pkg::req_t                acc,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lcdt_pkg::rsp_t                res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lcdt_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MATCH  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    lcdt_pkg::req_t                req_reg;
    logic [lcdt_pkg::CFG_BITS-1:0] size_reg;
    logic [OCC_W-1:0]              occ_reg;
    logic [OCC_W-1:0]              occ_next;
    lcdt_pkg::rsp_t                res_reg;
    lcdt_pkg::rsp_t                res_next;
    logic                          res_valid_reg;

    logic [lcdt_pkg::KEY_BITS-1:0] cell_key [ENTRIES];
    logic [ENTRIES-1:0]            cell_valid;
    logic [ENTRIES-1:0]            cell_dirty;
    logic [ENTRIES-1:0]            cell_match;
    logic [ENTRIES-1:0]            cell_load;
    logic [ENTRIES-1:0]            valid_ext;

    logic                          hit_any;
    logic [IDX_W-1:0]              hit_idx;
    logic                          hit_dirty;
    logic [lcdt_pkg::KEY_BITS-1:0] lru_key;
    logic                          lru_dirty;
    logic [OCC_W-1:0]              size_use;
    logic                          full;
    logic                          is_access;
    logic                          miss_full;
    logic [IDX_W-1:0]              stop_idx;
    logic                          fire;
    logic                          new_dirty;

    lcdt_pkg::stats_upd_t          upd;
    lcdt_pkg::counts_t             cnt_next;

    assign acc_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign fire      = (state_reg == ST_UPDATE) && (!res_valid_reg || res_ready);
    assign is_access = (req_reg.req_type == lcdt_pkg::REQ_ACCESS);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Encode hit position and pick the least recent (last live) cell;
    // valid_ext[i] is the valid bit of the cell to the right of cell i
    assign valid_ext = {1'b0, cell_valid[ENTRIES-1:1]};

    always_comb
    begin
        hit_any   = |cell_match;
        hit_idx   = '0;
        hit_dirty = 1'b0;
        lru_key   = '0;
        lru_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            hit_dirty = hit_dirty | (cell_match[i] & cell_dirty[i]);
            if (cell_valid[i] && !valid_ext[i])
            begin
                lru_key   = lru_key | cell_key[i];
                lru_dirty = lru_dirty | cell_dirty[i];
            end
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            size_use = OCC_W'(1);
        end
        else if (32'(size_reg) > 32'(ENTRIES))
        begin
            size_use = OCC_W'(ENTRIES);
        end
        else
        begin
            size_use = OCC_W'(size_reg);
        end
    end

    assign full      = (occ_reg >= size_use);
    assign miss_full = is_access && !hit_any && full;
    assign new_dirty = req_reg.is_write | (hit_any & hit_dirty);

    // Last cell that shifts: hit position, last live cell on eviction,
    // first free cell otherwise
    always_comb
    begin
        if (hit_any)
        begin
            stop_idx = hit_idx;
        end
        else if (full)
        begin
            stop_idx = IDX_W'(occ_reg - OCC_W'(1));
        end
        else
        begin
            stop_idx = IDX_W'(occ_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic [lcdt_pkg::KEY_BITS-1:0] in_key;
            logic                          in_dirty;

            assign cell_load[g] = fire && is_access && (32'(stop_idx) >= 32'(g));

            if (g == 0)
            begin : g_head
                assign in_key   = req_reg.page_key;
                assign in_dirty = new_dirty;
            end
            else
            begin : g_body
                assign in_key   = cell_key[g-1];
                assign in_dirty = cell_dirty[g-1];
            end

            lcdt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (cell_load[g]),
                .in_key   (in_key),
                .in_dirty (in_dirty),
                .cmp_key  (req_reg.page_key),
                .key      (cell_key[g]),
                .valid    (cell_valid[g]),
                .dirty    (cell_dirty[g]),
                .match    (cell_match[g])
            );
        end
    endgenerate

    always_comb
    begin
        upd.fire        = fire;
        upd.access      = is_access;
        upd.clear       = !is_access;
        upd.hit         = hit_any;
        upd.wr          = req_reg.is_write;
        upd.dirty_evict = miss_full && lru_dirty;
    end

    lcdt_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .cnt_next (cnt_next)
    );

    always_comb
    begin
        occ_next = occ_reg;
        if (is_access && !hit_any && !full)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_comb
    begin
        res_next.hit               = is_access && hit_any;
        res_next.evicted           = miss_full;
        res_next.evicted_key       = miss_full ? lru_key : '0;
        res_next.evicted_dirty     = miss_full && lru_dirty;
        res_next.call_count        = cnt_next.call_count;
        res_next.hit_count         = cnt_next.hit_count;
        res_next.read_hit_count    = cnt_next.read_hit_count;
        res_next.write_hit_count   = cnt_next.write_hit_count;
        res_next.dirty_evict_count = cnt_next.dirty_evict_count;
    end

    always_ff @(posedge clk)
    begin
        if (acc_valid && acc_ready)
        begin
            req_reg <= acc;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= lcdt_pkg::CACHE_SIZE_RESET;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            if (fire)
            begin
                occ_reg       <= occ_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
